FILE: rtl/fcsg_pkg.sv
// Shared constants, codes and helpers for the filled circle span generator.
// No dependencies; compile first.
package fcsg_pkg;

    localparam int COORD_WIDTH_DEF  = 16;
    localparam int RADIUS_WIDTH_DEF = 11;
    localparam int QUEUE_DEPTH      = 2;

    // input action codes
    localparam logic ACTION_START = 1'b0;
    localparam logic ACTION_STEP  = 1'b1;

    // which of the four spans of one iteration is being sent
    typedef enum logic [1:0] {
        SPAN_ROW_PX,   // row cy+x, columns cx-y..cx+y
        SPAN_ROW_MX,   // row cy-x, columns cx-y..cx+y
        SPAN_ROW_PY,   // row cy+y, columns cx-x..cx+x
        SPAN_ROW_MY    // row cy-y, columns cx-x..cx+x, carries the last flag
    } span_sel_t;

    // iteration x/y are signed, one bit of headroom over radius plus sign
    function automatic int step_width(int rw);
        return rw + 2;
    endfunction

    // job word: {cx, cy, x, y, color, done}
    function automatic int job_width(int cw, int rw);
        return 2 * cw + 2 * step_width(rw) + 32 + 1;
    endfunction

endpackage

FILE: rtl/fcsg_req_if.sv
// Request channel: valid/ready plus start/step payload.
// Depends on fcsg_pkg for default widths.
interface fcsg_req_if #(
    parameter int COORD_WIDTH  = fcsg_pkg::COORD_WIDTH_DEF,
    parameter int RADIUS_WIDTH = fcsg_pkg::RADIUS_WIDTH_DEF
);
    logic                           valid;
    logic                           ready;
    logic                           action;
    logic signed [COORD_WIDTH-1:0]  center_x;
    logic signed [COORD_WIDTH-1:0]  center_y;
    logic        [RADIUS_WIDTH-1:0] radius;
    logic        [31:0]             fill_color;

    modport source (
        output valid, action, center_x, center_y, radius, fill_color,
        input  ready
    );
    modport sink (
        input  valid, action, center_x, center_y, radius, fill_color,
        output ready
    );
endinterface

FILE: rtl/fcsg_span_if.sv
// Span result channel: valid/ready plus one horizontal span.
// Depends on fcsg_pkg for default widths.
interface fcsg_span_if #(
    parameter int COORD_WIDTH = fcsg_pkg::COORD_WIDTH_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_WIDTH:0]  span_row;
    logic signed [COORD_WIDTH:0]  span_first;
    logic signed [COORD_WIDTH:0]  span_final;
    logic        [31:0]           span_color;
    logic                         last_span;

    modport source (
        output valid, span_row, span_first, span_final, span_color, last_span,
        input  ready
    );
    modport sink (
        input  valid, span_row, span_first, span_final, span_color, last_span,
        output ready
    );
endinterface

FILE: rtl/filled_circle_span_generator.sv
// Filled circle span generator, top level: front end, job queue, back end.
// Depends on fcsg_pkg, fcsg_req_if, fcsg_span_if, fcsg_front, fcsg_queue,
// fcsg_back.
//
// Usage:
//   req  : valid/ready request channel. action = start loads center, radius
//          and color and produces no spans; action = step runs one midpoint
//          iteration and produces four spans. A step while idle is taken
//          and dropped. A start while a circle runs replaces it; spans of
//          steps already taken are still sent.
//   span : valid/ready result channel, one horizontal span per transfer,
//          last_span set on the fourth span of the final iteration.
// A step's first span passes the job queue, the back end's job register and
//   the output register. Throughput: one span per cycle while the receiver
//   is ready, set by the back end sending the four spans of each step through
//   the single output register. The two-entry job queue lets the front keep
//   taking steps while the back end works or the receiver stalls.
// Reset: asynchronous, clears the queue and output and leaves the block
//   idle. A stalled receiver holds the span steady and backs up into the
//   queue, after which req.ready drops.
module filled_circle_span_generator #(
    parameter int COORD_WIDTH  = fcsg_pkg::COORD_WIDTH_DEF,
    parameter int RADIUS_WIDTH = fcsg_pkg::RADIUS_WIDTH_DEF
) (
    input  logic clk,
    input  logic rst_n,
    fcsg_req_if.sink    req,
    fcsg_span_if.source span
);
    import fcsg_pkg::*;

    localparam int JW = job_width(COORD_WIDTH, RADIUS_WIDTH);

    logic          push;
    logic          pop;
    logic          q_full;
    logic          q_valid;
    logic [JW-1:0] job;
    logic [JW-1:0] q_data;

    fcsg_front #(
        .COORD_WIDTH  (COORD_WIDTH),
        .RADIUS_WIDTH (RADIUS_WIDTH)
    ) u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .full  (q_full),
        .push  (push),
        .job   (job)
    );

    fcsg_queue #(
        .DATA_WIDTH (JW),
        .DEPTH      (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (job),
        .full      (q_full),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_data    (q_data)
    );

    fcsg_back #(
        .COORD_WIDTH  (COORD_WIDTH),
        .RADIUS_WIDTH (RADIUS_WIDTH)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_data  (q_data),
        .pop     (pop),
        .span    (span)
    );

`ifndef SYNTHESIS
    // front must never write a full queue
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_full)
        else $error("job pushed into full queue");

    // back must never pop an empty queue
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_valid)
        else $error("job popped from empty queue");

    // a pushed job into an empty queue is visible next cycle
    a_push_seen: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !q_valid) |=> q_valid)
        else $error("pushed job not visible in queue");
`endif

endmodule

FILE: rtl/fcsg_front.sv
// Front end: takes start/step transfers, runs the midpoint decision update
// and pushes one job per productive step. Depends on fcsg_pkg, fcsg_req_if.
module fcsg_front #(
    parameter int COORD_WIDTH  = fcsg_pkg::COORD_WIDTH_DEF,
    parameter int RADIUS_WIDTH = fcsg_pkg::RADIUS_WIDTH_DEF
) (
    input  logic clk,
    input  logic rst_n,
    fcsg_req_if.sink req,
    input  logic full,
    output logic push,
    output logic [fcsg_pkg::job_width(COORD_WIDTH, RADIUS_WIDTH)-1:0] job
);
    import fcsg_pkg::*;

    localparam int XW = step_width(RADIUS_WIDTH);
    localparam int DW = RADIUS_WIDTH + 5;

    logic signed [XW-1:0]          x_reg, x_next;
    logic signed [XW-1:0]          y_reg, y_next;
    logic signed [DW-1:0]          d_reg, d_next;
    logic signed [COORD_WIDTH-1:0] cx_reg, cx_next;
    logic signed [COORD_WIDTH-1:0] cy_reg, cy_next;
    logic        [31:0]            color_reg, color_next;
    logic                          busy_reg, busy_next;

    logic                          xfer;
    logic signed [XW-1:0]          x_inc;
    logic signed [XW-1:0]          x_minus_y;
    logic signed [XW-1:0]          y_dec;
    logic                          done;

    assign req.ready = !full;
    assign xfer      = req.valid && req.ready;

    assign x_inc     = x_reg + XW'(1);
    assign x_minus_y = x_inc - y_reg;
    assign y_dec     = y_reg - XW'(1);
    // y only moves on a non-negative decision
    assign done      = d_reg[DW-1] ? (x_inc > y_reg) : (x_inc > y_dec);

    assign push = xfer && (req.action == ACTION_STEP) && busy_reg;
    assign job  = {cx_reg, cy_reg, x_reg, y_reg, color_reg, done};

    always_comb
    begin
        x_next     = x_reg;
        y_next     = y_reg;
        d_next     = d_reg;
        cx_next    = cx_reg;
        cy_next    = cy_reg;
        color_next = color_reg;
        busy_next  = busy_reg;
        if (xfer && (req.action == ACTION_START))
        begin
            x_next     = '0;
            y_next     = {2'b00, req.radius};
            d_next     = DW'(3) - {{(DW - RADIUS_WIDTH - 1){1'b0}}, req.radius, 1'b0};
            cx_next    = req.center_x;
            cy_next    = req.center_y;
            color_next = req.fill_color;
            busy_next  = 1'b1;
        end
        else if (push)
        begin
            x_next = x_inc;
            if (d_reg[DW-1])
            begin
                d_next = d_reg + ({{(DW - XW){x_inc[XW-1]}}, x_inc} <<< 2) + DW'(6);
            end
            else
            begin
                d_next = d_reg + ({{(DW - XW){x_minus_y[XW-1]}}, x_minus_y} <<< 2)
                         + DW'(10);
                y_next = y_dec;
            end
            busy_next = !done;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg     <= '0;
            y_reg     <= '0;
            d_reg     <= '0;
            cx_reg    <= '0;
            cy_reg    <= '0;
            color_reg <= '0;
            busy_reg  <= 1'b0;
        end
        else
        begin
            x_reg     <= x_next;
            y_reg     <= y_next;
            d_reg     <= d_next;
            cx_reg    <= cx_next;
            cy_reg    <= cy_next;
            color_reg <= color_next;
            busy_reg  <= busy_next;
        end
    end

endmodule

FILE: rtl/fcsg_queue.sv
// Small job FIFO between front and back end.
// No package dependencies beyond its parameters.
module fcsg_queue #(
    parameter int DATA_WIDTH = 8,
    parameter int DEPTH      = 2
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  logic [DATA_WIDTH-1:0] push_data,
    output logic                  full,
    input  logic                  pop,
    output logic                  q_valid,
    output logic [DATA_WIDTH-1:0] q_data
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]      count_reg, count_next;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_data  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: rtl/fcsg_back.sv
// Back end: pops jobs and sequences the four spans of each one into the
// registered output. Depends on fcsg_pkg, fcsg_span_if.
module fcsg_back #(
    parameter int COORD_WIDTH  = fcsg_pkg::COORD_WIDTH_DEF,
    parameter int RADIUS_WIDTH = fcsg_pkg::RADIUS_WIDTH_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic q_valid,
    input  logic [fcsg_pkg::job_width(COORD_WIDTH, RADIUS_WIDTH)-1:0] q_data,
    output logic pop,
    fcsg_span_if.source span
);
    import fcsg_pkg::*;

    localparam int XW = step_width(RADIUS_WIDTH);
    localparam int JW = job_width(COORD_WIDTH, RADIUS_WIDTH);
    localparam int SW = ((COORD_WIDTH > XW) ? COORD_WIDTH : XW) + 1;

    logic [JW-1:0]  job_reg, job_next;
    logic           cur_valid_reg, cur_valid_next;
    span_sel_t      sel_reg, sel_next;
    logic           out_valid_reg, out_valid_next;

    logic signed [COORD_WIDTH:0] row_reg, first_reg, final_reg;
    logic        [31:0]          color_reg;
    logic                        last_reg;

    logic signed [COORD_WIDTH-1:0] cx, cy;
    logic signed [XW-1:0]          x, y;
    logic        [31:0]            color;
    logic                          done;

    logic signed [SW-1:0] cx_w, cy_w, x_w, y_w;
    logic signed [SW-1:0] row_w, first_w, final_w;
    logic                 last_w;

    logic out_free, emit, cur_done;

    assign {cx, cy, x, y, color, done} = job_reg;

    assign cx_w = SW'(cx);
    assign cy_w = SW'(cy);
    assign x_w  = SW'(x);
    assign y_w  = SW'(y);

    always_comb
    begin
        last_w = 1'b0;
        case (sel_reg)
            SPAN_ROW_PX:
            begin
                row_w   = cy_w + x_w;
                first_w = cx_w - y_w;
                final_w = cx_w + y_w;
            end
            SPAN_ROW_MX:
            begin
                row_w   = cy_w - x_w;
                first_w = cx_w - y_w;
                final_w = cx_w + y_w;
            end
            SPAN_ROW_PY:
            begin
                row_w   = cy_w + y_w;
                first_w = cx_w - x_w;
                final_w = cx_w + x_w;
            end
            SPAN_ROW_MY:
            begin
                row_w   = cy_w - y_w;
                first_w = cx_w - x_w;
                final_w = cx_w + x_w;
                last_w  = done;
            end
            default:
            begin
                row_w   = '0;
                first_w = '0;
                final_w = '0;
            end
        endcase
    end

    assign out_free = !out_valid_reg || span.ready;
    assign emit     = cur_valid_reg && out_free;
    assign cur_done = emit && (sel_reg == SPAN_ROW_MY);
    assign pop      = q_valid && (!cur_valid_reg || cur_done);

    always_comb
    begin
        job_next       = job_reg;
        cur_valid_next = cur_valid_reg;
        sel_next       = sel_reg;
        if (pop)
        begin
            job_next       = q_data;
            cur_valid_next = 1'b1;
            sel_next       = SPAN_ROW_PX;
        end
        else if (cur_done)
        begin
            cur_valid_next = 1'b0;
        end
        else if (emit)
        begin
            case (sel_reg)
                SPAN_ROW_PX: sel_next = SPAN_ROW_MX;
                SPAN_ROW_MX: sel_next = SPAN_ROW_PY;
                SPAN_ROW_PY: sel_next = SPAN_ROW_MY;
                default:     sel_next = SPAN_ROW_PX;
            endcase
        end

        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (span.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            sel_reg       <= SPAN_ROW_PX;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            sel_reg       <= sel_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
        if (emit)
        begin
            row_reg   <= row_w[COORD_WIDTH:0];
            first_reg <= first_w[COORD_WIDTH:0];
            final_reg <= final_w[COORD_WIDTH:0];
            color_reg <= color;
            last_reg  <= last_w;
        end
    end

    assign span.valid      = out_valid_reg;
    assign span.span_row   = row_reg;
    assign span.span_first = first_reg;
    assign span.span_final = final_reg;
    assign span.span_color = color_reg;
    assign span.last_span  = last_reg;

endmodule

FILE: tb/tb_top.sv
// Testbench for filled_circle_span_generator: drives start/step requests and checks every
// span against an in-bench midpoint circle predictor held in a small scoreboard class.
// Depends on fcsg_pkg, fcsg_req_if, fcsg_span_if and the RTL of the block.
module tb_top;
    import fcsg_pkg::*;

    localparam int CW            = COORD_WIDTH_DEF;
    localparam int RW            = RADIUS_WIDTH_DEF;
    localparam int RANDOM_ITEMS  = 420;
    localparam int STALL_LIMIT   = 2000;
    localparam int TAIL_CYCLES   = 10;
    localparam int FULL_CIRCLE   = 100000;

    typedef struct packed {
        logic                  action;
        logic signed [CW-1:0]  cx;
        logic signed [CW-1:0]  cy;
        logic        [RW-1:0]  radius;
        logic        [31:0]    color;
    } circle_req_t;

    typedef struct packed {
        logic signed [CW:0]    row;
        logic signed [CW:0]    col_lo;
        logic signed [CW:0]    col_hi;
        logic        [31:0]    color;
        logic                  last;
    } span_t;

    class span_scoreboard;
        span_t     pending[$];
        int        errors;
        int        mid_x;
        int        mid_y;
        int        decision;
        int        org_x;
        int        org_y;
        bit [31:0] color;
        bit        busy;

        function new();
            errors   = 0;
            mid_x    = 0;
            mid_y    = 0;
            decision = 0;
            org_x    = 0;
            org_y    = 0;
            color    = '0;
            busy     = 1'b0;
        endfunction

        function void push_span(int row, int lo, int hi, bit last);
            span_t s;
            s.row    = row[CW:0];
            s.col_lo = lo[CW:0];
            s.col_hi = hi[CW:0];
            s.color  = color;
            s.last   = last;
            pending.push_back(s);
        endfunction

        // one accepted request: start loads the circle, a step while busy emits four spans
        function void note_request(circle_req_t r);
            int  nx;
            int  ny;
            bit  done;
            if (r.action == ACTION_START)
            begin
                org_x    = r.cx;
                org_y    = r.cy;
                color    = r.color;
                mid_x    = 0;
                mid_y    = r.radius;
                decision = 3 - 2 * mid_y;
                busy     = 1'b1;
                return;
            end
            if (!busy)
                return;
            nx = mid_x + 1;
            ny = mid_y;
            // decision update uses the incremented x
            if (decision < 0)
                decision += 4 * nx + 6;
            else
            begin
                decision += 4 * (nx - ny) + 10;
                ny--;
            end
            done = (nx > ny);
            push_span(org_y + mid_x, org_x - mid_y, org_x + mid_y, 1'b0);
            push_span(org_y - mid_x, org_x - mid_y, org_x + mid_y, 1'b0);
            push_span(org_y + mid_y, org_x - mid_x, org_x + mid_x, 1'b0);
            push_span(org_y - mid_y, org_x - mid_x, org_x + mid_x, done);
            mid_x = nx;
            mid_y = ny;
            if (done)
                busy = 1'b0;
        endfunction

        function bit field_differs(string name, logic signed [33:0] want,
                                   logic signed [33:0] got);
            if (want !== got)
            begin
                $display("%0t: span %s mismatch, expected %0d, got %0d",
                         $time, name, want, got);
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function void check_span(span_t got);
            span_t want;
            bit    bad;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected span, row %0d cols %0d..%0d",
                         $time, got.row, got.col_lo, got.col_hi);
                errors++;
                return;
            end
            want = pending.pop_front();
            bad  = 1'b0;
            bad |= field_differs("row",   want.row,    got.row);
            bad |= field_differs("first", want.col_lo, got.col_lo);
            bad |= field_differs("final", want.col_hi, got.col_hi);
            bad |= field_differs("color", want.color,  got.color);
            bad |= field_differs("last",  want.last,   got.last);
            if (bad)
                errors++;
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   calm;
    int   counted;
    int   stalled;

    span_scoreboard sb = new();

    fcsg_req_if  req_bus ();
    fcsg_span_if span_bus ();

    filled_circle_span_generator DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .span  (span_bus)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // receiver: random back-pressure, none while calm
    always @(negedge clk)
        span_bus.ready <= (rst_n === 1'b1) && (calm || $urandom_range(99) >= 20);

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && span_bus.valid === 1'b1 && span_bus.ready === 1'b1)
            sb.check_span({span_bus.span_row, span_bus.span_first, span_bus.span_final,
                           span_bus.span_color, span_bus.last_span});
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if ((req_bus.valid && req_bus.ready) || (span_bus.valid && span_bus.ready))
                stalled <= 0;
            else
                stalled <= stalled + 1;
            if (stalled >= STALL_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    task automatic send(input logic act, input logic [CW-1:0] cx, input logic [CW-1:0] cy,
                        input logic [RW-1:0] r, input logic [31:0] col);
        circle_req_t item;
        item = {act, cx, cy, r, col};
        while (!calm && $urandom_range(99) < 20)
        begin
            req_bus.valid <= 1'b0;
            @(negedge clk);
        end
        req_bus.valid      <= 1'b1;
        req_bus.action     <= act;
        req_bus.center_x   <= cx;
        req_bus.center_y   <= cy;
        req_bus.radius     <= r;
        req_bus.fill_color <= col;
        @(posedge clk);
        while (req_bus.ready !== 1'b1)
            @(posedge clk);
        // steps taken while idle do nothing and are not counted
        if (act == ACTION_START || sb.busy)
            counted++;
        sb.note_request(item);
        @(negedge clk);
    endtask

    // step with junk in the unused payload fields
    task automatic random_step();
        send(ACTION_STEP, CW'($urandom), CW'($urandom), RW'($urandom), $urandom);
    endtask

    task automatic run_circle(input logic [CW-1:0] cx, input logic [CW-1:0] cy,
                              input logic [RW-1:0] r, input logic [31:0] col,
                              input int max_steps);
        int n;
        n = 0;
        send(ACTION_START, cx, cy, r, col);
        while (sb.busy && n < max_steps)
        begin
            random_step();
            n++;
        end
    endtask

    initial
    begin
        int        base;
        int        rel;
        int        roll;
        int        steps;
        bit        drained;
        logic [RW-1:0] r;

        rst_n               = 1'b0;
        calm                = 1'b0;
        counted             = 0;
        stalled             = 0;
        drained             = 1'b0;
        req_bus.valid       = 1'b0;
        req_bus.action      = ACTION_START;
        req_bus.center_x    = '0;
        req_bus.center_y    = '0;
        req_bus.radius      = '0;
        req_bus.fill_color  = '0;
        span_bus.ready      = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: idle step, zero radius, extremes, restart while busy
        random_step();
        run_circle('0, '0, '0, 32'h0000_0000, FULL_CIRCLE);
        random_step();
        run_circle(16'sh7fff, 16'sh8000, 11'h7ff, 32'hffff_ffff, 3);
        run_circle(16'sh8000, 16'sh7fff, 11'd1, 32'ha5a5_5a5a, FULL_CIRCLE);
        random_step();
        run_circle(16'shffff, 16'sh0001, 11'd2, 32'h1234_5678, FULL_CIRCLE);
        run_circle(16'sd100, -16'sd100, 11'd7, 32'h00ff_00ff, FULL_CIRCLE);
        random_step();

        base = counted;
        while (counted < base + RANDOM_ITEMS)
        begin
            rel  = counted - base;
            calm = (rel >= 120 && rel < 240);
            if (!drained && rel >= 200)
            begin
                // hold off until the block has delivered everything
                req_bus.valid <= 1'b0;
                @(negedge clk);
                while (sb.pending.size() != 0)
                    @(negedge clk);
                drained = 1'b1;
            end
            roll = $urandom_range(99);
            if (roll < 8)
                random_step();
            else if (roll < 16)
                // broken sequence: a few steps, then the next start cuts it off
                run_circle(CW'($urandom), CW'($urandom), RW'($urandom), $urandom,
                           $urandom_range(0, 4));
            else
            begin
                r     = ($urandom_range(7) == 0) ? RW'($urandom) : RW'($urandom_range(0, 24));
                steps = (r > 40) ? $urandom_range(1, 10) : FULL_CIRCLE;
                run_circle(CW'($urandom), CW'($urandom), r, $urandom, steps);
            end
        end
        calm = 1'b0;
        req_bus.valid <= 1'b0;

        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

FILE: files.f
rtl/fcsg_pkg.sv
rtl/fcsg_req_if.sv
rtl/fcsg_span_if.sv
rtl/fcsg_front.sv
rtl/fcsg_queue.sv
rtl/fcsg_back.sv
rtl/filled_circle_span_generator.sv
tb/tb_top.sv
